// ===== rtl/ra_pkg.sv =====
// shared types, codes and constants for the ricart-agrawala node
`timescale 1ns / 1ps

package ra_pkg;

  localparam int ID_W       = 8;
  localparam int CNT_W      = 9;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int STEP_W     = $clog2(ID_W);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // opcodes of an incoming event
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_REPLY   = 2'd1;
  localparam logic [1:0] OP_WANT    = 2'd2;
  localparam logic [1:0] OP_LEAVE   = 2'd3;

  // kinds of a result
  localparam logic [1:0] KIND_SEND_REQ = 2'd0;
  localparam logic [1:0] KIND_SEND_REP = 2'd1;
  localparam logic [1:0] KIND_ENTER    = 2'd2;
  localparam logic [1:0] KIND_REJECT   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = CFG_IDX_W'(1);

  localparam int NODE_ID_RST_I    = 0;
  localparam int NODE_COUNT_RST_I = 5;
  localparam logic [ID_W-1:0]  NODE_ID_RST    = ID_W'(NODE_ID_RST_I);
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(NODE_COUNT_RST_I);
  localparam logic [ID_W-1:0]  NEXT_RST =
    ID_W'((NODE_ID_RST_I + 1) % NODE_COUNT_RST_I);
  localparam logic [ID_W-1:0]  PREV_RST =
    ID_W'((NODE_ID_RST_I + NODE_COUNT_RST_I - 1) % NODE_COUNT_RST_I);

  localparam logic [CNT_W-1:0] RING_MIN = CNT_W'(3);
  localparam logic [CNT_W-1:0] RING_MAX = CNT_W'(256);

  localparam logic [TIME_W-1:0] CLOCK_RST = TIME_W'(1);
  localparam logic [TIME_W-1:0] CLOCK_MAX = '1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WANT = 2'd1,
    PH_CRIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic            busy;
    logic [ID_W-1:0] next;
    logic [ID_W-1:0] prev;
  } ring_nbr_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   dest_node;
    logic [TIME_W-1:0] out_time;
    logic [TIME_W-1:0] clock_now;
    logic              last;
  } result_t;

endpackage

// ===== rtl/ricart_agrawala_node.sv =====
// top level of one ricart-agrawala mutual exclusion node
`timescale 1ns / 1ps

// usage:
// events enter on the in channel (opcode, sender_node, msg_time) and are taken
// at an edge with in_valid high and in_stall low. results leave on the out
// channel (kind, dest_node, out_time, clock_now, last), taken at an edge with
// out_valid high and out_stall low; last marks the final result of an event.
// an event waits in the input register until the queue has room for two
// results and no neighbour calculation runs; then its state update and up to
// two results are formed combinationally and written into a four-entry result
// queue; if the queue was empty, the first result shows on the out channel the
// cycle after that. one event per cycle is taken while in_stall stays low; the
// queue drains one result per cycle while out_stall is low.
// when the receiver stalls, the queue fills and in_stall rises while an event
// waits in the input register; nothing is dropped.
// the configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; a write restarts the neighbour calculation, which holds in_stall high
// until it ends. reset gives node_id 0, ring of 5, clock 1, phase idle,
// nothing deferred and an empty queue.

module ricart_agrawala_node import ra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [ID_W-1:0]      sender_node,
  input  logic [TIME_W-1:0]    msg_time,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           kind,
  output logic [ID_W-1:0]      dest_node,
  output logic [TIME_W-1:0]    out_time,
  output logic [TIME_W-1:0]    clock_now,
  output logic                 last,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  // configuration
  logic [ID_W-1:0]   node_id;
  logic [CNT_W-1:0]  node_count;
  logic [ID_W-1:0]   node_id_next;
  logic [CNT_W-1:0]  node_count_next;
  logic              cfg_we;
  ring_nbr_t         nbr;

  // input register
  logic              iv;
  logic [1:0]        in_op;
  logic [ID_W-1:0]   in_sender;
  logic [TIME_W-1:0] in_time;
  logic              in_take;
  logic              fire;

  // node state
  phase_t            phase;
  phase_t            phase_next;
  logic [TIME_W-1:0] lamport_clock;
  logic [TIME_W-1:0] request_time;
  logic [1:0]        reply_count;
  logic [TIME_W-1:0] deferred_time [2];
  logic [1:0]        deferred_valid;

  // event decode
  logic [TIME_W-1:0] clk_max;
  logic [TIME_W-1:0] clk_adv;
  logic [1:0]        reply_inc;
  logic              theirs_first;
  logic              defer;
  logic              hit_next;
  logic              hit_prev;
  logic              reject;

  // results
  result_t           res0;
  result_t           res1;
  logic [1:0]        n_res;

  // result queue
  result_t           fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp;
  logic [FIFO_AW-1:0] rp;
  logic [FIFO_CW-1:0] count;
  logic              pop;

  // ---------------- configuration ----------------

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    node_id_next    = node_id;
    node_count_next = node_count;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ID:    node_id_next    = cfg_data[ID_W-1:0];
        CFG_NODE_COUNT: node_count_next = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id    <= NODE_ID_RST;
      node_count <= NODE_COUNT_RST;
    end else begin
      node_id    <= node_id_next;
      node_count <= node_count_next;
    end
  end

  ra_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_we),
    .id_in    (node_id_next),
    .count_in (node_count_next),
    .nbr      (nbr)
  );

  // ---------------- input register ----------------

  // an event is processed once the queue has room for two results and no neighbour calculation runs
  assign fire     = iv && (count <= FIFO_CW'(FIFO_DEPTH - 2)) && !nbr.busy;
  assign in_stall = nbr.busy || (iv && !fire);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_take) begin
      iv <= 1'b1;
    end else if (fire) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op     <= opcode;
      in_sender <= sender_node;
      in_time   <= msg_time;
    end
  end

  // ---------------- event decode ----------------

  assign clk_max   = (lamport_clock > in_time) ? lamport_clock : in_time;
  assign clk_adv   = (clk_max == CLOCK_MAX) ? clk_max : clk_max + TIME_W'(1);
  assign reply_inc = reply_count + 2'd1;

  // (time, id) ordering against our own pending request
  assign theirs_first = (in_time < request_time) ||
                        ((in_time == request_time) && (in_sender < node_id));
  assign defer    = (phase == PH_CRIT) || ((phase == PH_WANT) && !theirs_first);
  assign hit_next = (in_sender == nbr.next);
  assign hit_prev = (in_sender == nbr.prev);

  always_comb begin
    unique case (in_op)
      OP_REQUEST: reject = defer && !hit_next && !hit_prev;
      OP_REPLY:   reject = (phase != PH_WANT);
      OP_WANT:    reject = (phase != PH_IDLE);
      OP_LEAVE:   reject = (phase != PH_CRIT);
      default:    reject = 1'b1;
    endcase
  end

  // ---------------- phase ----------------

  always_comb begin
    phase_next = phase;
    if (fire && !reject) begin
      unique case (in_op)
        OP_REPLY: if (reply_inc[1]) phase_next = PH_CRIT;
        OP_WANT:  phase_next = PH_WANT;
        OP_LEAVE: phase_next = PH_IDLE;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      lamport_clock  <= CLOCK_RST;
      request_time   <= '0;
      reply_count    <= '0;
      deferred_valid <= '0;
    end else begin
      phase <= phase_next;
      if (fire && !reject) begin
        case (in_op)
          OP_REQUEST: begin
            lamport_clock <= clk_adv;
            if (defer) begin
              if (hit_next) deferred_valid[0] <= 1'b1;
              else          deferred_valid[1] <= 1'b1;
            end
          end
          OP_REPLY: begin
            lamport_clock <= clk_adv;
            reply_count   <= reply_inc;
          end
          OP_WANT: begin
            reply_count  <= '0;
            request_time <= lamport_clock;
          end
          default: begin
            reply_count    <= '0;
            deferred_valid <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !reject && (in_op == OP_REQUEST) && defer) begin
      if (hit_next) deferred_time[0] <= in_time;
      else          deferred_time[1] <= in_time;
    end
  end

  // ---------------- results ----------------

  always_comb begin
    n_res = 2'd0;
    res0  = '{kind: KIND_REJECT, dest_node: '0, out_time: '0,
              clock_now: lamport_clock, last: 1'b1};
    res1  = res0;
    if (reject) begin
      n_res = 2'd1;
    end else begin
      case (in_op)
        OP_REQUEST: begin
          if (!defer) begin
            n_res = 2'd1;
            res0  = '{kind: KIND_SEND_REP, dest_node: in_sender, out_time: in_time,
                      clock_now: clk_adv, last: 1'b1};
          end
        end
        OP_REPLY: begin
          if (reply_inc[1]) begin
            n_res = 2'd1;
            res0  = '{kind: KIND_ENTER, dest_node: node_id, out_time: request_time,
                      clock_now: clk_adv, last: 1'b1};
          end
        end
        OP_WANT: begin
          n_res = 2'd2;
          res0  = '{kind: KIND_SEND_REQ, dest_node: nbr.next, out_time: lamport_clock,
                    clock_now: lamport_clock, last: 1'b0};
          res1  = '{kind: KIND_SEND_REQ, dest_node: nbr.prev, out_time: lamport_clock,
                    clock_now: lamport_clock, last: 1'b1};
        end
        default: begin
          // deferred replies, next neighbour first
          res0 = '{kind: KIND_SEND_REP, dest_node: nbr.next, out_time: deferred_time[0],
                   clock_now: lamport_clock, last: !deferred_valid[1]};
          res1 = '{kind: KIND_SEND_REP, dest_node: nbr.prev, out_time: deferred_time[1],
                   clock_now: lamport_clock, last: 1'b1};
          if (deferred_valid[0] && deferred_valid[1]) begin
            n_res = 2'd2;
          end else if (deferred_valid[0]) begin
            n_res = 2'd1;
          end else if (deferred_valid[1]) begin
            n_res = 2'd1;
            res0  = res1;
          end
        end
      endcase
    end
  end

  // ---------------- result queue ----------------

  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (fire) wp <= wp + FIFO_AW'(n_res);
      if (pop)  rp <= rp + FIFO_AW'(1);
      count <= count + (fire ? FIFO_CW'(n_res) : '0) - (pop ? FIFO_CW'(1) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (n_res != 2'd0)) fifo[wp] <= res0;
    if (fire && (n_res == 2'd2)) fifo[wp + FIFO_AW'(1)] <= res1;
  end

  assign out_valid = (count != '0);
  assign kind      = fifo[rp].kind;
  assign dest_node = fifo[rp].dest_node;
  assign out_time  = fifo[rp].out_time;
  assign clock_now = fifo[rp].clock_now;
  assign last      = fifo[rp].last;

  // ---------------- assertions ----------------

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_crit_from_want: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && phase == PH_CRIT && $past(phase) != PH_CRIT) |->
      $past(phase) == PH_WANT)
    else $error("critical section entered without waiting for replies");

  a_clock_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> lamport_clock >= $past(lamport_clock))
    else $error("lamport clock went backwards");

  a_no_fire_while_busy: assert property (@(posedge clk) disable iff (rst)
    nbr.busy |-> !fire)
    else $error("event processed with stale neighbours");

endmodule

// ===== rtl/ra_ring.sv =====
// ring neighbour calculation: node_id mod ring size, one quotient bit per cycle
`timescale 1ns / 1ps

module ra_ring import ra_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ID_W-1:0]  id_in,
  input  logic [CNT_W-1:0] count_in,
  output ring_nbr_t        nbr
);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [CNT_W-1:0]    rem;
  logic [ID_W-1:0]     dvd;
  logic [CNT_W-1:0]    div;
  logic [ID_W-1:0]     next;
  logic [ID_W-1:0]     prev;

  logic [CNT_W-1:0]    div_in;
  logic [CNT_W-1:0]    shifted;
  logic [CNT_W-1:0]    rem_step;
  logic [CNT_W-1:0]    rem_inc;
  logic [CNT_W-1:0]    rem_dec;
  logic [ID_W-1:0]     next_val;
  logic [ID_W-1:0]     prev_val;

  // ring size clamped to its legal range
  assign div_in = (count_in < RING_MIN) ? RING_MIN :
                  (count_in > RING_MAX) ? RING_MAX : count_in;

  // restoring division step
  assign shifted  = {rem[CNT_W-2:0], dvd[step]};
  assign rem_step = (shifted >= div) ? shifted - div : shifted;

  assign rem_inc  = rem_step + CNT_W'(1);
  assign rem_dec  = (rem_step == '0) ? div - CNT_W'(1) : rem_step - CNT_W'(1);
  assign next_val = (rem_inc == div) ? '0 : rem_inc[ID_W-1:0];
  assign prev_val = rem_dec[ID_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      next <= NEXT_RST;
      prev <= PREV_RST;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(ID_W - 1);
      rem  <= '0;
      dvd  <= id_in;
      div  <= div_in;
    end else if (busy) begin
      rem  <= rem_step;
      step <= step - STEP_W'(1);
      if (step == '0) begin
        busy <= 1'b0;
        next <= next_val;
        prev <= prev_val;
      end
    end
  end

  assign nbr.busy = busy;
  assign nbr.next = next;
  assign nbr.prev = prev;

endmodule

// ===== verif/ricart_agrawala_node_tb.sv =====
// self-checking testbench for the ricart-agrawala node: directed and random events vs a predictor
`timescale 1ns / 1ps

module ricart_agrawala_node_tb;
  import ra_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_EVENTS = 1200;

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [1:0]           opcode      = OP_REQUEST;
  logic [ID_W-1:0]      sender_node = '0;
  logic [TIME_W-1:0]    msg_time    = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [1:0]           kind;
  logic [ID_W-1:0]      dest_node;
  logic [TIME_W-1:0]    out_time;
  logic [TIME_W-1:0]    clock_now;
  logic                 last;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_NODE_ID;
  logic [CNT_W-1:0]     cfg_data    = '0;

  // predicted node state
  logic [ID_W-1:0]   my_id    = NODE_ID_RST;
  logic [CNT_W-1:0]  ring_cfg = NODE_COUNT_RST;
  phase_t            ph       = PH_IDLE;
  logic [TIME_W-1:0] lclock   = CLOCK_RST;
  logic [TIME_W-1:0] req_t    = '0;
  logic [1:0]        replies  = '0;
  logic [TIME_W-1:0] held_t [2] = '{'0, '0};
  logic              held_v [2] = '{1'b0, 1'b0};
  result_t           pending_msgs [$];

  bit steady = 1'b0;
  int errors = 0;
  int events_sent = 0;
  int results_seen = 0;
  int rejects = 0;
  int deferrals = 0;
  int ring_settings = 0;
  int pressure_pauses = 0;
  int idle_cycles = 0;
  int op_count [4] = '{0, 0, 0, 0};

  ricart_agrawala_node i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .sender_node(sender_node),
    .msg_time   (msg_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .dest_node  (dest_node),
    .out_time   (out_time),
    .clock_now  (clock_now),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int ring_size();
    if (ring_cfg < RING_MIN) return int'(RING_MIN);
    if (ring_cfg > RING_MAX) return int'(RING_MAX);
    return int'(ring_cfg);
  endfunction

  function automatic logic [ID_W-1:0] ring_next();
    return ID_W'((int'(my_id) + 1) % ring_size());
  endfunction

  function automatic logic [ID_W-1:0] ring_prev();
    return ID_W'((int'(my_id) + ring_size() - 1) % ring_size());
  endfunction

  function automatic logic [TIME_W-1:0] bumped_clock(logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] m;
    m = (lclock > t) ? lclock : t;
    return (m == CLOCK_MAX) ? CLOCK_MAX : m + 1'b1;
  endfunction

  function automatic void expect_msg(logic [1:0] k, logic [ID_W-1:0] d,
                                     logic [TIME_W-1:0] t, logic l);
    result_t r;
    r.kind      = k;
    r.dest_node = d;
    r.out_time  = t;
    r.clock_now = lclock;
    r.last      = l;
    pending_msgs.push_back(r);
  endfunction

  function automatic void predict_event(logic [1:0] op, logic [ID_W-1:0] snd,
                                        logic [TIME_W-1:0] t);
    logic defer;
    int   slot;
    int   n_held;
    int   sent;
    defer = 1'b0;
    case (op)
      OP_REQUEST: begin
        if (ph == PH_CRIT) begin
          defer = 1'b1;
        end else if (ph == PH_WANT) begin
          // ours wins on the earlier (time, id) pair
          defer = !((t < req_t) || (t == req_t && snd < my_id));
        end
        slot = (snd == ring_next()) ? 0 : (snd == ring_prev()) ? 1 : -1;
        if (!defer) begin
          lclock = bumped_clock(t);
          expect_msg(KIND_SEND_REP, snd, t, 1'b1);
        end else if (slot < 0) begin
          expect_msg(KIND_REJECT, '0, '0, 1'b1);
        end else begin
          lclock = bumped_clock(t);
          held_t[slot] = t;
          held_v[slot] = 1'b1;
          deferrals++;
        end
      end
      OP_REPLY: begin
        if (ph != PH_WANT) begin
          expect_msg(KIND_REJECT, '0, '0, 1'b1);
        end else begin
          lclock  = bumped_clock(t);
          replies = replies + 1'b1;
          if (replies >= 2'd2) begin
            ph = PH_CRIT;
            expect_msg(KIND_ENTER, my_id, req_t, 1'b1);
          end
        end
      end
      OP_WANT: begin
        if (ph != PH_IDLE) begin
          expect_msg(KIND_REJECT, '0, '0, 1'b1);
        end else begin
          ph      = PH_WANT;
          replies = '0;
          req_t   = lclock;
          expect_msg(KIND_SEND_REQ, ring_next(), req_t, 1'b0);
          expect_msg(KIND_SEND_REQ, ring_prev(), req_t, 1'b1);
        end
      end
      default: begin
        if (ph != PH_CRIT) begin
          expect_msg(KIND_REJECT, '0, '0, 1'b1);
        end else begin
          ph      = PH_IDLE;
          replies = '0;
          n_held  = int'(held_v[0]) + int'(held_v[1]);
          sent    = 0;
          for (int s = 0; s < 2; s++) begin
            if (held_v[s]) begin
              sent++;
              expect_msg(KIND_SEND_REP, (s == 0) ? ring_next() : ring_prev(), held_t[s],
                         sent == n_held);
              held_v[s] = 1'b0;
              held_t[s] = '0;
            end
          end
        end
      end
    endcase
  endfunction

  function automatic int field_mismatch(string name, logic [TIME_W-1:0] e,
                                        logic [TIME_W-1:0] a);
    if (a !== e) begin
      $error("%s mismatch: expected %0d, actual %0d", name, e, a);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < 35);

  always @(posedge clk) begin : check_results
    result_t want_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_msgs.size() == 0) begin
        $error("unexpected result: kind %0d dest %0d time %0d", kind, dest_node, out_time);
        errors++;
      end else begin
        want_r = pending_msgs.pop_front();
        if (want_r.kind == KIND_REJECT) rejects++;
        errors += field_mismatch("kind", TIME_W'(want_r.kind), TIME_W'(kind));
        errors += field_mismatch("dest_node", TIME_W'(want_r.dest_node), TIME_W'(dest_node));
        errors += field_mismatch("out_time", want_r.out_time, out_time);
        errors += field_mismatch("clock_now", want_r.clock_now, clock_now);
        errors += field_mismatch("last", TIME_W'(want_r.last), TIME_W'(last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no handshake for %0d cycles, %0d results outstanding", STALL_LIMIT,
               pending_msgs.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // one event on the event channel, predicted when taken
  task automatic send_event(logic [1:0] op, logic [ID_W-1:0] snd, logic [TIME_W-1:0] t);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    sender_node <= snd;
    msg_time    <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_event(op, snd, t);
    op_count[op]++;
    events_sent++;
  endtask

  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
    // events with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_ring(logic [ID_W-1:0] id, logic [CNT_W-1:0] n, bit poke_unused);
    settle_outputs();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NODE_ID;
    cfg_data  <= {1'($urandom_range(1)), id};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    my_id = id;
    cfg_index <= CFG_NODE_COUNT;
    cfg_data  <= n;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    ring_cfg = n;
    if (poke_unused) begin
      // no such register, nothing may change
      cfg_index <= CFG_IDX_W'($urandom_range(2, 255));
      cfg_data  <= CNT_W'($urandom);
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
    ring_settings++;
  endtask

  function automatic logic [ID_W-1:0] pick_sender();
    int r;
    r = $urandom_range(99);
    if (r < 40) return ring_next();
    if (r < 75) return ring_prev();
    return ID_W'($urandom_range(255));
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int     r;
    longint v;
    r = $urandom_range(99);
    if (r < 15) return $urandom;
    if (r < 35) return TIME_W'($urandom_range(64));
    // near the request time for ties, near the clock otherwise
    if (r < 70) v = longint'(req_t) + longint'($urandom_range(4)) - 2;
    else v = longint'(lclock) + longint'($urandom_range(5)) - 2;
    if (v < 0) v = 0;
    if (v > longint'(CLOCK_MAX)) v = longint'(CLOCK_MAX);
    return TIME_W'(v);
  endfunction

  task automatic send_shaped(logic [1:0] op);
    if ($urandom_range(99) < 12) begin
      send_event(2'($urandom_range(3)), ID_W'($urandom_range(255)), pick_time());
    end else begin
      send_event(op, pick_sender(), pick_time());
    end
  endtask

  task automatic run_mutex_round();
    int replies_left;
    repeat ($urandom_range(2)) send_shaped(OP_REQUEST);
    send_shaped(OP_WANT);
    replies_left = 2;
    while (replies_left > 0) begin
      if ($urandom_range(99) < 45) begin
        send_shaped(OP_REPLY);
        replies_left--;
      end else begin
        send_shaped(OP_REQUEST);
      end
    end
    repeat ($urandom_range(3)) send_shaped(OP_REQUEST);
    send_shaped(OP_LEAVE);
  endtask

  // reset ring: node 0 of 5
  task automatic test_default_ring();
    send_event(OP_REPLY, NEXT_RST, 32'd7);
    send_event(OP_LEAVE, '0, '0);
    send_event(OP_REQUEST, 8'd3, '0);
    send_event(OP_REQUEST, 8'd255, 32'd100);
    send_event(OP_WANT, 8'hff, CLOCK_MAX);
    send_event(OP_WANT, '0, '0);
    send_event(OP_LEAVE, '0, '0);
    send_event(OP_REQUEST, NEXT_RST, 32'd200);
    send_event(OP_REQUEST, 8'd2, 32'd300);
    // same time, higher id loses the tie
    send_event(OP_REQUEST, PREV_RST, req_t);
    send_event(OP_REQUEST, 8'd2, 32'd50);
    send_event(OP_REPLY, NEXT_RST, 32'd10);
    send_event(OP_REPLY, 8'd200, 32'd1000);
    send_event(OP_REQUEST, NEXT_RST, 32'd400);
    send_event(OP_WANT, '0, '0);
    send_event(OP_REPLY, PREV_RST, '0);
    send_event(OP_LEAVE, '0, '0);
  endtask

  task automatic test_ring_extremes();
    program_ring(8'd255, 9'd256, 1'b0);
    send_event(OP_WANT, '0, '0);
    // same time, lower id wins the tie
    send_event(OP_REQUEST, ring_prev(), req_t);
    send_event(OP_REPLY, ring_next(), lclock);
    send_event(OP_REPLY, ring_prev(), '0);
    send_event(OP_LEAVE, '0, '0);
    // ring below range, id beyond the ring
    program_ring(8'd7, 9'd0, 1'b1);
    send_event(OP_WANT, 8'hff, CLOCK_MAX);
    send_event(OP_REQUEST, ring_next(), req_t + 1'b1);
    send_event(OP_REPLY, '0, '0);
    send_event(OP_REPLY, '0, '0);
    send_event(OP_LEAVE, '0, '0);
  endtask

  task automatic test_random_rounds();
    int              start;
    int              next_cfg;
    int              next_pause;
    logic [CNT_W-1:0] n;
    start      = events_sent;
    next_cfg   = start + 200;
    next_pause = start + 130;
    program_ring(ID_W'($urandom_range(255)), 9'd511, 1'b1);
    while (events_sent - start < RANDOM_EVENTS) begin
      if (events_sent >= next_cfg) begin
        case ($urandom_range(3))
          0: n = CNT_W'($urandom_range(3, 8));
          1: n = CNT_W'($urandom_range(9, 256));
          2: n = CNT_W'($urandom_range(0, 511));
          default: n = CNT_W'($urandom_range(0, 2));
        endcase
        program_ring(ID_W'($urandom_range(255)), n, 1'($urandom_range(1)));
        next_cfg += 200;
      end
      if (events_sent >= next_pause) begin
        settle_outputs();
        pressure_pauses++;
        next_pause += 170;
      end
      steady <= (events_sent - start >= 450) && (events_sent - start < 700);
      run_mutex_round();
    end
    steady <= 1'b0;
  endtask

  task automatic test_clock_saturation();
    while (ph != PH_IDLE) send_event((ph == PH_WANT) ? OP_REPLY : OP_LEAVE, '0, '0);
    send_event(OP_REQUEST, ring_next(), CLOCK_MAX - 1'b1);
    send_event(OP_REQUEST, ID_W'($urandom_range(255)), CLOCK_MAX);
    send_event(OP_WANT, '0, '0);
    send_event(OP_REQUEST, ring_next(), CLOCK_MAX);
    send_event(OP_REPLY, '0, CLOCK_MAX);
    send_event(OP_REPLY, '0, '0);
    send_event(OP_LEAVE, '0, '0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_default_ring();
    test_ring_extremes();
    test_random_rounds();
    test_clock_saturation();
    settle_outputs();
    $display("covered %0d events: %0d requests, %0d replies, %0d wants, %0d leaves",
             events_sent, op_count[OP_REQUEST], op_count[OP_REPLY], op_count[OP_WANT],
             op_count[OP_LEAVE]);
    $display("checked %0d results (%0d rejected), %0d deferrals, %0d ring settings, %0d drains",
             results_seen, rejects, deferrals, ring_settings, pressure_pauses);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ra_pkg.sv
rtl/ra_ring.sv
rtl/ricart_agrawala_node.sv
verif/ricart_agrawala_node_tb.sv
